@@ hdl/ols_pkg.sv @@
package ols_pkg;

    localparam int FLEN_W   = 16;
    localparam int ADDR_W   = 22;
    localparam int USED_W   = 6;
    localparam int CNT_W    = 8;
    localparam int STATUS_W = 3;
    localparam int SBYTES_W = 16;

    localparam logic [SBYTES_W-1:0] SLOT_BYTES_RST = 16'd1024;
    localparam logic [CNT_W-1:0]    CNT_MAX        = 8'hFF;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_IGNORED     = 3'd1,
        ST_EMPTY       = 3'd2,
        ST_STORAGE_ERR = 3'd3,
        ST_DISCARDED   = 3'd4
    } status_t;

    typedef struct packed {
        logic              cmd;
        logic [FLEN_W-1:0] frame_length;
        logic              storage_failed;
    } ols_req_t;

    typedef struct packed {
        status_t           status;
        logic [FLEN_W-1:0] length_out;
        logic [ADDR_W-1:0] slot_address;
        logic [USED_W-1:0] entries_used;
        logic [CNT_W-1:0]  write_errors;
        logic [CNT_W-1:0]  read_errors;
    } ols_rsp_t;

    // Saturating increment of an error counter
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
        return r;
    endfunction

endpackage

@@ hdl/ols_in_stage.sv @@
module ols_in_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ols_pkg::ols_req_t in_req,
    input  logic             take,
    output logic             req_valid,
    output ols_pkg::ols_req_t req
);
    import ols_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    ols_req_t req_reg;

    // Accept a new request whenever the register is empty or being drained
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_req;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

@@ hdl/ols_stack_core.sv @@
module ols_stack_core
#(
    parameter int RING_DEPTH = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [ols_pkg::SBYTES_W-1:0]   cfg_wr_data,
    input  logic                           fire,
    input  ols_pkg::ols_req_t              req,
    output ols_pkg::ols_rsp_t              rsp
);
    import ols_pkg::*;

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
    localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W+1)'(RING_DEPTH);
    localparam int PROD_W = IDX_W + SBYTES_W;

    logic [SBYTES_W-1:0] slot_bytes_reg;
    logic [IDX_W-1:0]    top_reg, top_next;
    logic [IDX_W-1:0]    bot_reg, bot_next;
    logic [FLEN_W-1:0]   top_len_reg, top_len_next;
    logic [CNT_W-1:0]    wfail_reg, wfail_next;
    logic [CNT_W-1:0]    rfail_reg, rfail_next;

    // Length store: one write port, one prefetch read port for the entry below top
    logic [FLEN_W-1:0]   mem [RING_DEPTH];
    logic [FLEN_W-1:0]   below_len_reg;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [FLEN_W-1:0]   mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;

    logic [IDX_W-1:0]    top_inc, top_dec, bot_inc;
    logic [IDX_W-1:0]    slot;
    logic                touched;
    status_t             status;
    logic [FLEN_W-1:0]   len_out;
    logic [PROD_W-1:0]   product;
    logic [IDX_W:0]      used_wide;

    // Hold the slot size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_bytes_reg <= SLOT_BYTES_RST;
        end
        else if (cfg_wr_en)
        begin
            slot_bytes_reg <= cfg_wr_data;
        end
    end

    // Ring neighbors of the pointers
    assign top_inc = (top_reg == IDX_LAST) ? '0 : top_reg + 1'b1;
    assign top_dec = (top_reg == '0) ? IDX_LAST : top_reg - 1'b1;
    assign bot_inc = (bot_reg == IDX_LAST) ? '0 : bot_reg + 1'b1;

    // Decode the request and form the next state
    always_comb
    begin
        top_next     = top_reg;
        bot_next     = bot_reg;
        top_len_next = top_len_reg;
        wfail_next   = wfail_reg;
        rfail_next   = rfail_reg;
        mem_we       = 1'b0;
        mem_waddr    = top_reg;
        mem_wdata    = '0;
        slot         = top_reg;
        touched      = 1'b0;
        status       = ST_OK;
        len_out      = '0;
        case (req.cmd)
            CMD_PUSH:
            begin
                if (req.frame_length == '0)
                begin
                    status = ST_IGNORED;
                end
                else
                begin
                    slot    = top_inc;
                    touched = 1'b1;
                    if (req.storage_failed)
                    begin
                        wfail_next = sat_inc(wfail_reg);
                        status     = ST_STORAGE_ERR;
                    end
                    else
                    begin
                        wfail_next = '0;
                        if (top_inc == bot_reg)
                        begin
                            bot_next = bot_inc;
                        end
                        top_next     = top_inc;
                        top_len_next = req.frame_length;
                        mem_we       = fire;
                        mem_waddr    = top_inc;
                        mem_wdata    = req.frame_length;
                    end
                end
            end
            CMD_POP:
            begin
                if (top_reg == bot_reg)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    touched = 1'b1;
                    if (top_len_reg == '0)
                    begin
                        status = ST_DISCARDED;
                    end
                    else if (req.storage_failed)
                    begin
                        rfail_next = sat_inc(rfail_reg);
                        status     = ST_STORAGE_ERR;
                    end
                    else
                    begin
                        rfail_next = '0;
                        len_out    = top_len_reg;
                    end
                    // Clear the slot and step back onto the prefetched entry
                    mem_we       = fire;
                    mem_waddr    = top_reg;
                    mem_wdata    = '0;
                    top_next     = top_dec;
                    top_len_next = below_len_reg;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
        if (!fire)
        begin
            top_next     = top_reg;
            bot_next     = bot_reg;
            top_len_next = top_len_reg;
            wfail_next   = wfail_reg;
            rfail_next   = rfail_reg;
        end
    end

    // Advance pointers, cached top length and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg     <= '0;
            bot_reg     <= '0;
            top_len_reg <= '0;
            wfail_reg   <= '0;
            rfail_reg   <= '0;
        end
        else
        begin
            top_reg     <= top_next;
            bot_reg     <= bot_next;
            top_len_reg <= top_len_next;
            wfail_reg   <= wfail_next;
            rfail_reg   <= rfail_next;
        end
    end

    // Prefetch the entry below the next top, bypassing a same-cycle write
    assign mem_raddr = (top_next == '0) ? IDX_LAST : top_next - 1'b1;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_we && (mem_waddr == mem_raddr))
        begin
            below_len_reg <= mem_wdata;
        end
        else
        begin
            below_len_reg <= mem[mem_raddr];
        end
    end

    // Slot byte address and fill level
    assign product   = PROD_W'(slot) * PROD_W'(slot_bytes_reg);
    assign used_wide = (top_next >= bot_next)
                       ? {1'b0, top_next} - {1'b0, bot_next}
                       : {1'b0, top_next} + DEPTH_EXT - {1'b0, bot_next};

    assign rsp.status       = status;
    assign rsp.length_out   = len_out;
    assign rsp.slot_address = touched ? ADDR_W'(product) : '0;
    assign rsp.entries_used = USED_W'(used_wide);
    assign rsp.write_errors = wfail_next;
    assign rsp.read_errors  = rfail_next;

endmodule

@@ hdl/ols_out_stage.sv @@
module ols_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  ols_pkg::ols_rsp_t rsp_in,
    output logic              out_valid,
    input  logic              out_ready,
    output ols_pkg::ols_rsp_t rsp_out
);
    import ols_pkg::*;

    logic     valid_reg;
    ols_rsp_t rsp_reg;

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_in;
        end
    end

    assign out_valid = valid_reg;
    assign rsp_out   = rsp_reg;

endmodule

@@ hdl/overwriting_lifo_slot_stack.sv @@
// Overwriting LIFO slot stack.
// Requests enter on the s_axis channel: tuser carries the command (push or
// pop), tdata the frame length and the storage-failed flag. Each request
// yields exactly one result on the m_axis channel: status in tuser; popped
// length, slot byte address, fill level and both error counters in tdata.
// The slot size is written through cfg_wr_en/cfg_wr_data; write it only while
// idle, as the block does not enforce this. A request accepted on s_axis is
// held in the input register, processed once the result register is free or
// being drained, and its result is registered and presented on m_axis.
// Throughput: one request per cycle while m_axis is not stalled. Each request
// reads the cached top length and updates the pointers; the length memory's
// single read port prefetches the entry below top every cycle so a pop can be
// followed by another pop directly.
// Reset empties the stack, clears the error counters and sets the slot size
// to 1024 bytes; no clearing pass is needed, so requests are taken at once.
// When the receiver stalls, the result register holds, the input register
// fills, and s_axis_tready drops until the result is taken.
module overwriting_lifo_slot_stack
#(
    parameter int RING_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,     // slot_bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // frame_length[15:0], storage_failed[16], zero pad
    input  logic        s_axis_tuser,    // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,    // length_out[15:0], slot_address[37:16],
                                         // entries_used[43:38], write_errors[51:44],
                                         // read_errors[59:52], zero pad
    output logic [2:0]  m_axis_tuser     // status
);
    import ols_pkg::*;

    ols_req_t in_req;
    ols_req_t req;
    ols_rsp_t rsp;
    ols_rsp_t rsp_out;
    logic     req_valid;
    logic     fire;

    // Unpack the request
    assign in_req.cmd            = s_axis_tuser;
    assign in_req.frame_length   = s_axis_tdata[15:0];
    assign in_req.storage_failed = s_axis_tdata[16];

    // Process when the result register is free or being drained
    assign fire = req_valid && (!m_axis_tvalid || m_axis_tready);

    ols_in_stage u_in_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_req    (in_req),
        .take      (fire),
        .req_valid (req_valid),
        .req       (req)
    );

    ols_stack_core #(
        .RING_DEPTH (RING_DEPTH)
    ) u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .req         (req),
        .rsp         (rsp)
    );

    ols_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .rsp_in    (rsp),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .rsp_out   (rsp_out)
    );

    // Pack the result
    assign m_axis_tuser = rsp_out.status;
    assign m_axis_tdata = {4'b0000, rsp_out.read_errors, rsp_out.write_errors,
                           rsp_out.entries_used, rsp_out.slot_address,
                           rsp_out.length_out};

    a_stall_backs_up: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while the result side was free");

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_axis_tvalid)
        else $error("processed request produced no result");

    a_ignored_touches_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (rsp_out.status == ST_IGNORED))
        |-> (rsp_out.slot_address == '0) && (rsp_out.length_out == '0))
        else $error("ignored push reported a slot or a length");

    a_empty_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (rsp_out.status == ST_EMPTY))
        |-> (rsp_out.entries_used == '0) && (rsp_out.slot_address == '0))
        else $error("empty pop reported entries or an address");

endmodule
